### design/ascon_aead128_encrypt_defines.svh
// Assertion macros shared by the Ascon-AEAD128 encryption RTL.
`ifndef ASCON_AEAD128_ENCRYPT_DEFINES_SVH
`define ASCON_AEAD128_ENCRYPT_DEFINES_SVH

`ifndef SYNTHESIS

// Property checked every cycle outside reset.
`define ASC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("ascon assertion failed");

// Consequence checked in the cycle after the antecedent, outside reset.
`define ASC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ascon assertion failed");

`else

`define ASC_ASSERT(lbl, prop)

`define ASC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### design/asc_pkg.sv
// Types, constants and permutation functions for the Ascon-AEAD128 encryption block.
`default_nettype none

package asc_pkg;

    localparam int unsigned LANE_W = 64;
    localparam int unsigned RATE_W = 128;

    typedef logic [4:0][LANE_W-1:0] t_lanes;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_AD    = 2'd1,
        OP_MSG   = 2'd2
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [LANE_W-1:0] lo;
        logic [LANE_W-1:0] hi;
        logic [4:0]        nbytes;
        logic              fin;
        logic              first;
    } t_req;

    localparam logic [4:0]        BLOCK_BYTES = 5'd16;
    localparam logic [LANE_W-1:0] ASCON_IV    = 64'h00001000808c0001;
    localparam logic [LANE_W-1:0] DOMAIN_BIT  = 64'h8000000000000000;
    localparam logic [LANE_W-1:0] PAD_LOW     = 64'h0000000000000001;

    localparam logic [3:0] RND_START12 = 4'd0;
    localparam logic [3:0] RND_START8  = 4'd4;
    localparam logic [3:0] RND_LAST    = 4'd11;

    localparam logic CFG_KEY_LOW  = 1'b0;
    localparam logic CFG_KEY_HIGH = 1'b1;

    // Round constants run 0xf0, 0xe1, ... 0x4b over the twelve rounds.
    function automatic logic [7:0] round_const(logic [3:0] idx);
        return {4'hF - idx, idx};
    endfunction

    function automatic logic [LANE_W-1:0] rotr(logic [LANE_W-1:0] x, int unsigned n);
        logic [2*LANE_W-1:0] t;
        t = {x, x} >> n;
        return t[LANE_W-1:0];
    endfunction

    function automatic t_lanes ascon_round(t_lanes s, logic [7:0] c);
        logic [LANE_W-1:0] a0, a1, a2, a3, a4;
        logic [LANE_W-1:0] b0, b1, b2, b3, b4;
        logic [LANE_W-1:0] t0, t1, t2, t3;
        t_lanes            r;
        a1 = s[1];
        a3 = s[3];
        a0 = s[0] ^ s[4];
        a4 = s[4] ^ s[3];
        a2 = s[2] ^ {56'd0, c} ^ s[1];
        b0 = a0 ^ (~a1 & a2);
        b1 = a1 ^ (~a2 & a3);
        b2 = a2 ^ (~a3 & a4);
        b3 = a3 ^ (~a4 & a0);
        b4 = a4 ^ (~a0 & a1);
        t1 = b1 ^ b0;
        t0 = b0 ^ b4;
        t3 = b3 ^ b2;
        t2 = ~b2;
        r[0] = t0 ^ rotr(t0, 19) ^ rotr(t0, 28);
        r[1] = t1 ^ rotr(t1, 61) ^ rotr(t1, 39);
        r[2] = t2 ^ rotr(t2, 1) ^ rotr(t2, 6);
        r[3] = t3 ^ rotr(t3, 10) ^ rotr(t3, 17);
        r[4] = b4 ^ rotr(b4, 7) ^ rotr(b4, 41);
        return r;
    endfunction

    // Low n bytes set; n of 16 or more gives all ones.
    function automatic logic [RATE_W-1:0] byte_mask(logic [4:0] n);
        logic [RATE_W-1:0] m;
        for (int i = 0; i < 16; i++) begin
            m[8*i +: 8] = (5'(i) < n) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    // Padding byte 0x01 placed at byte n of the rate.
    function automatic logic [RATE_W-1:0] pad_bits(logic [4:0] n);
        logic [RATE_W-1:0] p;
        for (int i = 0; i < 16; i++) begin
            p[8*i +: 8] = (5'(i) == n) ? 8'h01 : 8'h00;
        end
        return p;
    endfunction

endpackage

`default_nettype wire

### design/asc_front.sv
// Front end: accepts requests, tracks the protocol phase and queues the work to do.
`default_nettype none

module asc_front (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_req_type,
    input  wire logic [63:0]  i_word_low,
    input  wire logic [63:0]  i_word_high,
    input  wire logic [4:0]   i_byte_count,
    input  wire logic         i_is_final_chunk,
    input  wire logic         i_queue_full,
    output logic              o_push,
    output asc_pkg::t_req     o_req
);
    import asc_pkg::*;

    `include "ascon_aead128_encrypt_defines.svh"

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_READY  = 4'b0010,
        PH_ADDONE = 4'b0100,
        PH_MSG    = 4'b1000
    } t_phase;

    t_phase     r_phase, n_phase;
    logic       r_ad_open, n_ad_open;
    logic       accept;
    logic [4:0] nbytes;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;

    // A chunk that is not the last one is always a full block.
    assign nbytes = (!i_is_final_chunk || (i_byte_count > BLOCK_BYTES)) ? BLOCK_BYTES
                                                                         : i_byte_count;

    always_comb begin
        n_phase      = r_phase;
        n_ad_open    = r_ad_open;
        o_push       = 1'b0;
        o_req.op     = t_op'(i_req_type);
        o_req.lo     = i_word_low;
        o_req.hi     = i_word_high;
        o_req.nbytes = nbytes;
        o_req.fin    = i_is_final_chunk;
        o_req.first  = (r_phase != PH_MSG);
        if (accept) begin
            case (t_op'(i_req_type))
                OP_START: begin
                    o_push    = 1'b1;
                    n_phase   = PH_READY;
                    n_ad_open = 1'b0;
                end
                OP_AD: begin
                    if (r_phase == PH_READY) begin
                        if (nbytes == BLOCK_BYTES) begin
                            o_push    = 1'b1;
                            n_ad_open = !i_is_final_chunk;
                            if (i_is_final_chunk) begin
                                n_phase = PH_ADDONE;
                            end
                        end else begin
                            // Empty associated data with nothing absorbed only closes it.
                            o_push    = (nbytes != 5'd0) || r_ad_open;
                            n_ad_open = 1'b0;
                            n_phase   = PH_ADDONE;
                        end
                    end
                end
                OP_MSG: begin
                    if ((r_phase != PH_IDLE) && !r_ad_open) begin
                        o_push  = 1'b1;
                        n_phase = i_is_final_chunk ? PH_IDLE : PH_MSG;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_ad_open <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_ad_open <= n_ad_open;
        end
    end

    `ASC_ASSERT(a_ad_open_in_ready, !r_ad_open || (r_phase == PH_READY))
    `ASC_ASSERT_NEXT(a_start_opens, o_push && (o_req.op == OP_START),
                     (r_phase == PH_READY) && !r_ad_open)
    `ASC_ASSERT_NEXT(a_last_msg_closes, o_push && (o_req.op == OP_MSG) && o_req.fin,
                     r_phase == PH_IDLE)

endmodule

`default_nettype wire

### design/asc_queue.sv
// Short request queue between the front end and the permutation engine.
`default_nettype none

module asc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire asc_pkg::t_req i_data,
    output logic               o_full,
    output logic               o_valid,
    output asc_pkg::t_req      o_data,
    input  wire logic          i_pop
);
    import asc_pkg::*;

    `include "ascon_aead128_encrypt_defines.svh"

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_req             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `ASC_ASSERT(a_no_overflow, !(i_push && o_full && !i_pop))
    `ASC_ASSERT(a_no_underflow, !i_pop || (r_count != '0))
    `ASC_ASSERT_NEXT(a_count_up, i_push && !i_pop, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

### design/asc_back.sv
// Back end: round-per-cycle Ascon permutation engine with a registered result stage.
`default_nettype none

module asc_back (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic [63:0]  i_key_low,
    input  wire logic [63:0]  i_key_high,
    input  wire logic         i_req_valid,
    input  wire asc_pkg::t_req i_req,
    output logic              o_pop,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [63:0]       o_out_low,
    output logic [63:0]       o_out_high,
    output logic [4:0]        o_out_bytes,
    output logic              o_is_tag,
    output logic              o_last_result
);
    import asc_pkg::*;

    `include "ascon_aead128_encrypt_defines.svh"

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_PERM = 3'b010,
        B_POST = 3'b100
    } t_bstate;

    // What follows the permutation that is running.
    typedef enum logic [2:0] {
        CT_DONE    = 3'd0,
        CT_KEY34   = 3'd1,
        CT_PADPERM = 3'd2,
        CT_FINAL   = 3'd3,
        CT_TAG     = 3'd4
    } t_cont;

    t_bstate           r_state, n_state;
    t_cont             r_cont, n_cont;
    logic [3:0]        r_rnd, n_rnd;
    t_lanes            r_lanes, n_lanes;
    logic              r_out_valid, n_out_valid;
    logic [63:0]       r_out_low, r_out_high;
    logic [4:0]        r_out_bytes;
    logic              r_out_tag;

    logic              out_free;
    logic [RATE_W-1:0] mask, pad, rate_abs, ct;
    logic              full_blk;
    logic              emit, emit_tag;
    logic [63:0]       emit_low, emit_high;
    logic [4:0]        emit_bytes;

    assign out_free = !r_out_valid || i_out_ready;
    assign mask     = byte_mask(i_req.nbytes);
    assign pad      = pad_bits(i_req.nbytes);
    assign full_blk = (i_req.nbytes == BLOCK_BYTES);
    assign rate_abs = {r_lanes[1], r_lanes[0]} ^ ({i_req.hi, i_req.lo} & mask);
    assign ct       = rate_abs & mask;

    always_comb begin
        n_state    = r_state;
        n_cont     = r_cont;
        n_rnd      = r_rnd;
        n_lanes    = r_lanes;
        o_pop      = 1'b0;
        emit       = 1'b0;
        emit_tag   = 1'b0;
        emit_low   = ct[63:0];
        emit_high  = ct[127:64];
        emit_bytes = i_req.nbytes;
        case (r_state)
            B_IDLE: begin
                if (i_req_valid && out_free) begin
                    o_pop = 1'b1;
                    case (i_req.op)
                        OP_START: begin
                            n_lanes = {i_req.hi, i_req.lo, i_key_high, i_key_low, ASCON_IV};
                            n_rnd   = RND_START12;
                            n_cont  = CT_KEY34;
                            n_state = B_PERM;
                        end
                        OP_AD: begin
                            {n_lanes[1], n_lanes[0]} = full_blk ? rate_abs : (rate_abs ^ pad);
                            n_rnd   = RND_START8;
                            n_cont  = (full_blk && i_req.fin) ? CT_PADPERM : CT_DONE;
                            n_state = B_PERM;
                        end
                        OP_MSG: begin
                            emit = 1'b1;
                            if (i_req.first) begin
                                n_lanes[4] = r_lanes[4] ^ DOMAIN_BIT;
                            end
                            if (full_blk) begin
                                {n_lanes[1], n_lanes[0]} = rate_abs;
                                n_rnd  = RND_START8;
                                n_cont = i_req.fin ? CT_FINAL : CT_DONE;
                            end else begin
                                // Partial block is always the last one: go to finalization.
                                {n_lanes[1], n_lanes[0]} = rate_abs ^ pad;
                                n_lanes[2] = r_lanes[2] ^ i_key_low;
                                n_lanes[3] = r_lanes[3] ^ i_key_high;
                                n_rnd  = RND_START12;
                                n_cont = CT_TAG;
                            end
                            n_state = B_PERM;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            B_PERM: begin
                n_lanes = ascon_round(r_lanes, round_const(r_rnd));
                n_rnd   = r_rnd + 1'b1;
                if (r_rnd == RND_LAST) begin
                    n_state = B_POST;
                end
            end
            B_POST: begin
                case (r_cont)
                    CT_DONE: begin
                        n_state = B_IDLE;
                    end
                    CT_KEY34: begin
                        n_lanes[3] = r_lanes[3] ^ i_key_low;
                        n_lanes[4] = r_lanes[4] ^ i_key_high;
                        n_state    = B_IDLE;
                    end
                    CT_PADPERM: begin
                        n_lanes[0] = r_lanes[0] ^ PAD_LOW;
                        n_rnd      = RND_START8;
                        n_cont     = CT_DONE;
                        n_state    = B_PERM;
                    end
                    CT_FINAL: begin
                        n_lanes[0] = r_lanes[0] ^ PAD_LOW;
                        n_lanes[2] = r_lanes[2] ^ i_key_low;
                        n_lanes[3] = r_lanes[3] ^ i_key_high;
                        n_rnd      = RND_START12;
                        n_cont     = CT_TAG;
                        n_state    = B_PERM;
                    end
                    CT_TAG: begin
                        if (out_free) begin
                            emit       = 1'b1;
                            emit_tag   = 1'b1;
                            emit_low   = r_lanes[3] ^ i_key_low;
                            emit_high  = r_lanes[4] ^ i_key_high;
                            emit_bytes = BLOCK_BYTES;
                            n_state    = B_IDLE;
                        end
                    end
                    default: begin
                        n_state = B_IDLE;
                    end
                endcase
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_cont      <= CT_DONE;
            r_rnd       <= RND_START12;
            r_lanes     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cont      <= n_cont;
            r_rnd       <= n_rnd;
            r_lanes     <= n_lanes;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_low   <= emit_low;
            r_out_high  <= emit_high;
            r_out_bytes <= emit_bytes;
            r_out_tag   <= emit_tag;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_low     = r_out_low;
    assign o_out_high    = r_out_high;
    assign o_out_bytes   = r_out_bytes;
    assign o_is_tag      = r_out_tag;
    assign o_last_result = r_out_tag;

    `ASC_ASSERT(a_round_in_range, (r_state != B_PERM) || (r_rnd <= RND_LAST))
    `ASC_ASSERT_NEXT(a_result_held, r_out_valid && !i_out_ready,
                     r_out_valid && $stable(r_out_low) && $stable(r_out_tag))
    `ASC_ASSERT_NEXT(a_ad_permutes, o_pop && (i_req.op == OP_AD), r_state == B_PERM)

endmodule

`default_nettype wire

### design/ascon_aead128_encrypt.sv
// Top level of the Ascon-AEAD128 encryption block: key registers, front end, queue, engine.
// One permutation round per cycle; the engine works on one request at a time and takes it
// from the queue when idle with a free result register. A start runs the long permutation,
// an associated-data or message block the short one, a last full associated-data block
// one more for padding, and a last message chunk the long finalization, then the tag.
// Synchronous active-low reset clears the key, the phase tracking, the queue and the engine.
`default_nettype none

module ascon_aead128_encrypt #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_cfg_we,
    input  wire logic [0:0]   i_cfg_index,
    input  wire logic [63:0]  i_cfg_data,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire logic [1:0]   i_req_type,
    input  wire logic [63:0]  i_word_low,
    input  wire logic [63:0]  i_word_high,
    input  wire logic [4:0]   i_byte_count,
    input  wire logic         i_is_final_chunk,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [63:0]       o_out_low,
    output logic [63:0]       o_out_high,
    output logic [4:0]        o_out_bytes,
    output logic              o_is_tag,
    output logic              o_last_result
);
    import asc_pkg::*;

    logic [63:0] r_key_low, r_key_high;
    logic        q_full, q_valid, push, pop;
    t_req        push_req, head_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    asc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_word_low       (i_word_low),
        .i_word_high      (i_word_high),
        .i_byte_count     (i_byte_count),
        .i_is_final_chunk (i_is_final_chunk),
        .i_queue_full     (q_full),
        .o_push           (push),
        .o_req            (push_req)
    );

    asc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_req),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_data  (head_req),
        .i_pop   (pop)
    );

    asc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_low     (r_key_low),
        .i_key_high    (r_key_high),
        .i_req_valid   (q_valid),
        .i_req         (head_req),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_low     (o_out_low),
        .o_out_high    (o_out_high),
        .o_out_bytes   (o_out_bytes),
        .o_is_tag      (o_is_tag),
        .o_last_result (o_last_result)
    );

endmodule

`default_nettype wire

### bench/ascon_aead128_encrypt_checker.sv
// Checker for the Ascon-AEAD128 encryption block: tracks the cipher state and compares every result.
module ascon_aead128_encrypt_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [63:0] i_word_low,
    input  wire logic [63:0] i_word_high,
    input  wire logic [4:0]  i_byte_count,
    input  wire logic        i_is_final_chunk,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [63:0] i_out_low,
    input  wire logic [63:0] i_out_high,
    input  wire logic [4:0]  i_out_bytes,
    input  wire logic        i_is_tag,
    input  wire logic        i_last_result,
    output int               o_mismatches,
    output int               o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    // Round constants of rounds 0 to 11, round 0 in the top byte.
    localparam logic [95:0] ROUND_CONSTS = 96'hf0e1d2c3b4a5968778695a4b;
    localparam int          REPORT_LIMIT = 100;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_NONCE,
        SEQ_AD_CLOSED,
        SEQ_MSG
    } t_seq_phase;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  nbytes;
        logic        tag;
        logic        last;
    } t_cipher_chunk;

    logic [4:0][63:0] st;
    logic [63:0]      key_lo;
    logic [63:0]      key_hi;
    t_seq_phase       phase;
    logic             ad_open;
    t_cipher_chunk    expected_chunks[$];
    t_cipher_chunk    want;

    function automatic logic [63:0] ror64(logic [63:0] x, int unsigned n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [63:0] lane_mask(int unsigned n);
        if (n >= 8) begin
            return '1;
        end
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    task automatic sbox_round(logic [7:0] rc);
        logic [63:0] x0, x1, x2, x3, x4;
        logic [63:0] y0, y1, y2, y3, y4;
        x0 = st[0] ^ st[4];
        x1 = st[1];
        x2 = st[2] ^ {56'd0, rc} ^ st[1];
        x3 = st[3];
        x4 = st[4] ^ st[3];
        y0 = x0 ^ (~x1 & x2);
        y1 = x1 ^ (~x2 & x3);
        y2 = x2 ^ (~x3 & x4);
        y3 = x3 ^ (~x4 & x0);
        y4 = x4 ^ (~x0 & x1);
        y1 ^= y0;
        y0 ^= y4;
        y3 ^= y2;
        y2 = ~y2;
        st[0] = y0 ^ ror64(y0, 19) ^ ror64(y0, 28);
        st[1] = y1 ^ ror64(y1, 61) ^ ror64(y1, 39);
        st[2] = y2 ^ ror64(y2, 1) ^ ror64(y2, 6);
        st[3] = y3 ^ ror64(y3, 10) ^ ror64(y3, 17);
        st[4] = y4 ^ ror64(y4, 7) ^ ror64(y4, 41);
    endtask

    // The short permutation runs the last rounds of the long one.
    task automatic run_rounds(int unsigned rounds);
        for (int unsigned r = 12 - rounds; r < 12; r++) begin
            sbox_round(ROUND_CONSTS[8 * (11 - r) +: 8]);
        end
    endtask

    task automatic mix_partial(logic [63:0] lo, logic [63:0] hi, int unsigned n);
        if (n >= 8) begin
            st[0] ^= lo;
            st[1] ^= hi & lane_mask(n - 8);
        end else begin
            st[0] ^= lo & lane_mask(n);
        end
    endtask

    task automatic pad_rate(int unsigned n);
        if (n >= 8) begin
            st[1] ^= 64'h01 << (8 * (n - 8));
        end else begin
            st[0] ^= 64'h01 << (8 * n);
        end
    endtask

    task automatic queue_chunk(logic [63:0] lo, logic [63:0] hi, int unsigned nb,
                               logic tag, logic last);
        t_cipher_chunk c;
        c.lo = lo;
        c.hi = hi;
        c.nbytes = nb[4:0];
        c.tag = tag;
        c.last = last;
        expected_chunks.insert(expected_chunks.size(), c);
    endtask

    task automatic predict_request(logic [1:0] kind, logic [63:0] lo, logic [63:0] hi,
                                   logic [4:0] cnt, logic fin);
        int unsigned n;
        n = (!fin || cnt > BLOCK_BYTES) ? 16 : int'(cnt);
        if (kind == OP_START) begin
            st[0] = ASCON_IV;
            st[1] = key_lo;
            st[2] = key_hi;
            st[3] = lo;
            st[4] = hi;
            run_rounds(12);
            st[3] ^= key_lo;
            st[4] ^= key_hi;
            phase = SEQ_NONCE;
            ad_open = 1'b0;
        end else if (kind == OP_AD) begin
            if (phase == SEQ_NONCE) begin
                if (n == 16) begin
                    st[0] ^= lo;
                    st[1] ^= hi;
                    run_rounds(8);
                    ad_open = 1'b1;
                    if (fin) begin
                        pad_rate(0);
                        run_rounds(8);
                    end
                end else if (n > 0 || ad_open) begin
                    mix_partial(lo, hi, n);
                    pad_rate(n);
                    run_rounds(8);
                end
                // An empty last chunk with nothing absorbed only closes the data.
                if (fin) begin
                    ad_open = 1'b0;
                    phase = SEQ_AD_CLOSED;
                end
            end
        end else if (kind == OP_MSG) begin
            if (phase != SEQ_IDLE && !ad_open) begin
                if (phase != SEQ_MSG) begin
                    st[4] ^= DOMAIN_BIT;
                    phase = SEQ_MSG;
                end
                if (n == 16) begin
                    st[0] ^= lo;
                    st[1] ^= hi;
                    queue_chunk(st[0], st[1], 16, 1'b0, 1'b0);
                    run_rounds(8);
                end else begin
                    mix_partial(lo, hi, n);
                    if (n >= 8) begin
                        queue_chunk(st[0], st[1] & lane_mask(n - 8), n, 1'b0, 1'b0);
                    end else begin
                        queue_chunk(st[0] & lane_mask(n), '0, n, 1'b0, 1'b0);
                    end
                end
                if (fin) begin
                    pad_rate(n == 16 ? 0 : n);
                    st[2] ^= key_lo;
                    st[3] ^= key_hi;
                    run_rounds(12);
                    st[3] ^= key_lo;
                    st[4] ^= key_hi;
                    queue_chunk(st[3], st[4], 16, 1'b1, 1'b1);
                    phase = SEQ_IDLE;
                end
            end
        end
    endtask

    task automatic compare_field(string field, logic [63:0] exp_val, logic [63:0] got);
        if (exp_val !== got) begin
            o_mismatches++;
            // Every mismatch is counted; the report stops after a while to keep the log short.
            if (o_mismatches <= REPORT_LIMIT) begin
                $error("%s: expected %h, got %h", field, exp_val, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            st = '0;
            key_lo = '0;
            key_hi = '0;
            phase = SEQ_IDLE;
            ad_open = 1'b0;
            expected_chunks.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_KEY_LOW) begin
                    key_lo = i_cfg_data;
                end else if (i_cfg_index == CFG_KEY_HIGH) begin
                    key_hi = i_cfg_data;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (expected_chunks.size() == 0) begin
                    o_mismatches++;
                    if (o_mismatches <= REPORT_LIMIT) begin
                        $error("result with nothing expected: low %h high %h bytes %0d",
                               i_out_low, i_out_high, i_out_bytes);
                    end
                end else begin
                    want = expected_chunks.pop_front();
                    compare_field("out_low", want.lo, i_out_low);
                    compare_field("out_high", want.hi, i_out_high);
                    compare_field("out_bytes", 64'(want.nbytes), 64'(i_out_bytes));
                    compare_field("is_tag", 64'(want.tag), 64'(i_is_tag));
                    compare_field("last_result", 64'(want.last), 64'(i_last_result));
                end
            end
            if (i_in_valid && i_in_ready) begin
                predict_request(i_req_type, i_word_low, i_word_high, i_byte_count,
                                i_is_final_chunk);
            end
        end
        o_outstanding = expected_chunks.size();
    end

endmodule

### bench/testbench.sv
// Top of the encryption testbench: clock, reset, key writes, request stimulus and the verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import asc_pkg::*;

    localparam logic [1:0] REQ_UNKNOWN   = 2'd3;
    localparam int         SETTLE_CYCLES = 80;
    localparam int         STALL_LIMIT   = 2000;
    localparam int         PHASE_ITEMS   = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic [1:0]  i_req_type = '0;
    logic [63:0] i_word_low = '0;
    logic [63:0] i_word_high = '0;
    logic [4:0]  i_byte_count = '0;
    logic        i_is_final_chunk = 1'b0;
    logic        i_out_ready = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [63:0] o_out_low;
    logic [63:0] o_out_high;
    logic [4:0]  o_out_bytes;
    logic        o_is_tag;
    logic        o_last_result;

    int chk_mismatches;
    int chk_outstanding;
    int burst_left = 0;
    int useful_items = 0;
    bit steady_sender = 1'b0;

    ascon_aead128_encrypt u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_word_low       (i_word_low),
        .i_word_high      (i_word_high),
        .i_byte_count     (i_byte_count),
        .i_is_final_chunk (i_is_final_chunk),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_out_low        (o_out_low),
        .o_out_high       (o_out_high),
        .o_out_bytes      (o_out_bytes),
        .o_is_tag         (o_is_tag),
        .o_last_result    (o_last_result)
    );

    ascon_aead128_encrypt_checker u_chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_word_low       (i_word_low),
        .i_word_high      (i_word_high),
        .i_byte_count     (i_byte_count),
        .i_is_final_chunk (i_is_final_chunk),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_out_low        (o_out_low),
        .i_out_high       (o_out_high),
        .i_out_bytes      (o_out_bytes),
        .i_is_tag         (o_is_tag),
        .i_last_result    (o_last_result),
        .o_mismatches     (chk_mismatches),
        .o_outstanding    (chk_outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // The receiver alternates open and stalled runs, with an occasional long open stretch.
    initial begin
        int   run;
        logic level;
        run = 0;
        level = 1'b0;
        forever begin
            @(posedge i_clk);
            if (run == 0) begin
                level = !level;
                if (level) begin
                    run = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
                end else begin
                    run = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                      : $urandom_range(1, 6);
                end
            end
            run--;
            i_out_ready <= level;
        end
    end

    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("ascon_aead128_encrypt: mismatch");
        $finish;
    end

    function automatic logic [63:0] rnd_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Byte count of a chunk that is not the last one; the block treats it as a full block.
    function automatic logic [4:0] body_count();
        return ($urandom_range(0, 5) == 0) ? 5'($urandom) : BLOCK_BYTES;
    endfunction

    function automatic logic [4:0] tail_count();
        return ($urandom_range(0, 7) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
    endfunction

    // Entered and left at a rising edge; the request is accepted at the edge it returns on.
    task automatic send_req(logic [1:0] kind, logic [63:0] lo, logic [63:0] hi,
                            logic [4:0] cnt, logic fin);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!steady_sender && $urandom_range(0, 2) != 0) begin
                gap = $urandom_range(1, 10);
            end
        end
        burst_left--;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= kind;
        i_word_low <= lo;
        i_word_high <= hi;
        i_byte_count <= cnt;
        i_is_final_chunk <= fin;
        @(negedge i_clk);
        while (!o_in_ready) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic send_noise();
        send_req(2'($urandom_range(0, 3)), rnd_word(), rnd_word(), 5'($urandom), 1'($urandom));
    endtask

    // Since requests without a result may still be in the engine, extra cycles follow.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (chk_outstanding != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_key(logic [63:0] lo, logic [63:0] hi);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_KEY_LOW;
        i_cfg_data <= lo;
        @(posedge i_clk);
        i_cfg_index <= CFG_KEY_HIGH;
        i_cfg_data <= hi;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // One message: nonce, optional associated data, message chunks and the tag.
    // A few sessions carry out-of-order requests or stop before the last chunk.
    task automatic run_session();
        int ad_blocks;
        int msg_blocks;
        bit with_ad;
        bit cut_short;
        with_ad = $urandom_range(0, 3) != 0;
        ad_blocks = $urandom_range(0, 3);
        msg_blocks = $urandom_range(0, 3);
        cut_short = $urandom_range(0, 11) == 0;
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 3)) send_noise();
        end
        send_req(OP_START, rnd_word(), rnd_word(), 5'($urandom), 1'($urandom));
        useful_items++;
        if (with_ad) begin
            repeat (ad_blocks) begin
                send_req(OP_AD, rnd_word(), rnd_word(), body_count(), 1'b0);
                useful_items++;
            end
            if ($urandom_range(0, 9) == 0) begin
                send_req(OP_MSG, rnd_word(), rnd_word(), tail_count(), 1'($urandom));
            end
            send_req(OP_AD, rnd_word(), rnd_word(), tail_count(), 1'b1);
            useful_items++;
        end
        repeat (msg_blocks) begin
            send_req(OP_MSG, rnd_word(), rnd_word(), body_count(), 1'b0);
            useful_items++;
        end
        if ($urandom_range(0, 9) == 0) begin
            send_req(OP_AD, rnd_word(), rnd_word(), tail_count(), 1'($urandom));
        end
        if (!cut_short) begin
            send_req(OP_MSG, rnd_word(), rnd_word(), tail_count(), 1'b1);
            useful_items++;
        end
        if ($urandom_range(0, 9) == 0) begin
            send_req($urandom_range(0, 1) ? OP_MSG : OP_AD, rnd_word(), rnd_word(),
                     tail_count(), 1'($urandom));
        end
    endtask

    initial begin
        int target;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_key('1, '0);
        // Requests before any nonce, and an unknown request type, are dropped.
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd4, 1'b1);
        send_req(OP_AD, rnd_word(), rnd_word(), 5'd4, 1'b1);
        send_req(REQ_UNKNOWN, '1, '1, '1, 1'b1);
        // Empty associated data and an empty message.
        send_req(OP_START, '1, '1, 5'd31, 1'b1);
        send_req(OP_AD, '1, '1, 5'd0, 1'b1);
        send_req(OP_MSG, '1, '1, 5'd0, 1'b1);
        // Full last blocks on both sides, each followed by a padding block.
        send_req(OP_START, '0, '0, 5'd0, 1'b0);
        send_req(OP_AD, rnd_word(), rnd_word(), BLOCK_BYTES, 1'b1);
        send_req(OP_MSG, '0, '0, BLOCK_BYTES, 1'b1);
        // Out-of-order requests around open and closed associated data.
        send_req(OP_START, rnd_word(), rnd_word(), 5'd0, 1'b0);
        send_req(OP_AD, rnd_word(), rnd_word(), 5'd5, 1'b0);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd9, 1'b1);
        send_req(OP_AD, rnd_word(), rnd_word(), 5'd15, 1'b1);
        send_req(OP_AD, rnd_word(), rnd_word(), 5'd15, 1'b1);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd3, 1'b0);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd20, 1'b1);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd2, 1'b1);
        // A new nonce in the middle of a message drops it.
        send_req(OP_START, rnd_word(), rnd_word(), 5'd0, 1'b0);
        send_req(OP_MSG, rnd_word(), rnd_word(), BLOCK_BYTES, 1'b0);
        send_req(OP_START, rnd_word(), rnd_word(), 5'd0, 1'b0);
        send_req(OP_AD, '1, '1, 5'd8, 1'b1);
        send_req(OP_MSG, '1, '1, 5'd7, 1'b1);
        // A message with no associated data at all.
        send_req(OP_START, rnd_word(), rnd_word(), 5'd0, 1'b0);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd9, 1'b1);
        send_req(OP_MSG, rnd_word(), rnd_word(), 5'd1, 1'b1);

        for (int p = 0; p < 6; p++) begin
            wait_for_drain();
            case (p)
                0: load_key('0, '0);
                1: load_key('1, '1);
                3: load_key('0, '1);
                4: load_key(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
                default: load_key({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            steady_sender = (p == 2);
            target = useful_items + PHASE_ITEMS;
            while (useful_items < target) run_session();
        end

        wait_for_drain();
        if (chk_mismatches == 0 && chk_outstanding == 0) begin
            $display("ascon_aead128_encrypt: match");
        end else begin
            $display("ascon_aead128_encrypt: mismatch");
        end
        $finish;
    end

endmodule
